[design/efr_pkg.sv]
// ---------------------------------------------------------------------------
// efr_pkg
// Types, widths and helpers shared by the element frame rotation blocks.
// ---------------------------------------------------------------------------
package efr_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 30;
  localparam int EDGE_W     = COORD_BITS + 1;      // point differences
  localparam int NRM_W      = 2 * EDGE_W;          // first cross product
  localparam int RED_W      = FRAC_BITS + 1;       // reduced normal, signed
  localparam int VEC_W      = RED_W + EDGE_W;      // widest vector into a unit
  localparam int POS_W      = 6;
  localparam int UNIT_W     = FRAC_BITS + 1;       // normalised magnitude
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int QUO_W      = UNIT_W;
  localparam int NUM_W      = UNIT_W + FRAC_BITS + 1;
  localparam int COMP_W     = 32;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_WELL = 2'd1,
    KIND_FRAC = 2'd2,
    KIND_UNIT = 2'd3
  } efr_kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
    logic signed [COORD_BITS-1:0] third_x;
    logic signed [COORD_BITS-1:0] third_y;
    logic signed [COORD_BITS-1:0] third_z;
  } efr_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] tangent_x;
    logic signed [COMP_W-1:0] tangent_y;
    logic signed [COMP_W-1:0] tangent_z;
    logic signed [COMP_W-1:0] inplane_x;
    logic signed [COMP_W-1:0] inplane_y;
    logic signed [COMP_W-1:0] inplane_z;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;
    logic                     frame_status;
  } efr_out_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] e_x;
    logic signed [EDGE_W-1:0] e_y;
    logic signed [EDGE_W-1:0] e_z;
    logic signed [EDGE_W-1:0] h_x;
    logic signed [EDGE_W-1:0] h_y;
    logic signed [EDGE_W-1:0] h_z;
    logic                     e_zero;
  } efr_job_t;

  typedef struct packed {
    logic valid;
    logic bad;
  } efr_ctl_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } efr_vec_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } efr_col_t;

  // position of the highest set bit, 0 for zero
  function automatic logic [POS_W-1:0] efr_msb(input logic [VEC_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

endpackage

[design/efr_front.sv]
// ---------------------------------------------------------------------------
// efr_front
// Takes requests, forms the edge and picks the helper vector by element kind.
// ---------------------------------------------------------------------------
module efr_front
  import efr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  efr_kind_t kind,
  input  logic      in_valid,
  output logic      in_ready,
  input  efr_in_t   in_data,
  output logic      push,
  output efr_job_t  push_data,
  input  logic      q_full
);

  logic     front_v_r;
  efr_job_t job_r;
  efr_job_t job_nxt;

  assign push      = front_v_r && !q_full;
  assign in_ready  = !front_v_r || !q_full;
  assign push_data = job_r;

  always_comb begin
    logic signed [EDGE_W-1:0] ex, ey, ez;
    logic nx, ny, nz;
    ex = $signed({in_data.second_x[COORD_BITS-1], in_data.second_x})
       - $signed({in_data.first_x[COORD_BITS-1], in_data.first_x});
    ey = $signed({in_data.second_y[COORD_BITS-1], in_data.second_y})
       - $signed({in_data.first_y[COORD_BITS-1], in_data.first_y});
    ez = $signed({in_data.second_z[COORD_BITS-1], in_data.second_z})
       - $signed({in_data.first_z[COORD_BITS-1], in_data.first_z});
    nx = (ex != '0);
    ny = (ey != '0);
    nz = (ez != '0);
    job_nxt        = '0;
    job_nxt.e_x    = ex;
    job_nxt.e_y    = ey;
    job_nxt.e_z    = ez;
    job_nxt.e_zero = !nx && !ny && !nz;
    case (kind)
      KIND_WELL: begin
        if (nx && !ny && !nz) begin
          job_nxt.h_z = EDGE_W'(1);
        end else if (ny && !nx && !nz) begin
          job_nxt.h_x = EDGE_W'(1);
        end else if (nz && !nx && !ny) begin
          job_nxt.h_y = EDGE_W'(1);
        end else if (nx) begin
          job_nxt.h_x = -ex;
        end else if (ny) begin
          job_nxt.h_y = -ey;
        end else if (nz) begin
          job_nxt.h_z = -ez;
        end
      end
      KIND_FRAC: begin
        job_nxt.h_x = $signed({in_data.third_x[COORD_BITS-1], in_data.third_x})
                    - $signed({in_data.second_x[COORD_BITS-1], in_data.second_x});
        job_nxt.h_y = $signed({in_data.third_y[COORD_BITS-1], in_data.third_y})
                    - $signed({in_data.second_y[COORD_BITS-1], in_data.second_y});
        job_nxt.h_z = $signed({in_data.third_z[COORD_BITS-1], in_data.third_z})
                    - $signed({in_data.second_z[COORD_BITS-1], in_data.second_z});
      end
      default: begin
        // no helper: frame comes out degenerate
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (in_ready) begin
      front_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

[design/efr_queue.sv]
// ---------------------------------------------------------------------------
// efr_queue
// Short FIFO between the front and the back of the frame pipeline.
// ---------------------------------------------------------------------------
module efr_queue
  import efr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  efr_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output efr_job_t head
);

  efr_job_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[design/efr_cross.sv]
// ---------------------------------------------------------------------------
// efr_cross
// Both cross products with the reduction of the normal between them.
// ---------------------------------------------------------------------------
module efr_cross
  import efr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  efr_job_t in_job,
  output efr_ctl_t out_ctl,
  output efr_vec_t out_e,
  output efr_vec_t out_n,
  output efr_vec_t out_y
);

  efr_ctl_t                ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [EDGE_W-1:0] e3_r [3];
  logic signed [EDGE_W-1:0] e4_r [3];
  logic signed [EDGE_W-1:0] e5_r [3];
  logic signed [NRM_W-1:0]  n1_r [3];
  logic signed [NRM_W-1:0]  n2_r [3];
  logic signed [NRM_W-1:0]  n3_r [3];
  logic signed [NRM_W-1:0]  n4_r [3];
  logic signed [NRM_W-1:0]  n5_r [3];
  logic [NRM_W-1:0]         mag2_r [3];
  logic [NRM_W-1:0]         mag3_r [3];
  logic [2:0]               sgn2_r, sgn3_r;
  logic [NRM_W-1:0]         or2_r;
  logic [POS_W-1:0]         sh3_r;
  logic signed [RED_W-1:0]  np4_r [3];
  logic signed [VEC_W-1:0]  y5_r [3];
  efr_vec_t                 e6_r, n6_r, y6_r;

  logic [NRM_W-1:0] mag_c [3];
  logic [POS_W-1:0] pos_c;
  logic [POS_W-1:0] sh_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = n1_r[i][NRM_W-1] ? (~n1_r[i] + 1'b1) : n1_r[i];
    end
    pos_c = efr_msb(VEC_W'(or2_r));
    sh_c  = (pos_c >= POS_W'(FRAC_BITS)) ? (pos_c - POS_W'(FRAC_BITS - 1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else if (en) begin
      ctl1_r.valid <= in_valid;
      ctl1_r.bad   <= in_job.e_zero;
      e1_r[0] <= in_job.e_x;
      e1_r[1] <= in_job.e_y;
      e1_r[2] <= in_job.e_z;
      n1_r[0] <= in_job.e_y * in_job.h_z - in_job.e_z * in_job.h_y;
      n1_r[1] <= in_job.e_z * in_job.h_x - in_job.e_x * in_job.h_z;
      n1_r[2] <= in_job.e_x * in_job.h_y - in_job.e_y * in_job.h_x;

      ctl2_r.valid <= ctl1_r.valid;
      ctl2_r.bad   <= ctl1_r.bad || (n1_r[0] == '0 && n1_r[1] == '0 && n1_r[2] == '0);
      e2_r   <= e1_r;
      n2_r   <= n1_r;
      mag2_r <= mag_c;
      sgn2_r <= {n1_r[2][NRM_W-1], n1_r[1][NRM_W-1], n1_r[0][NRM_W-1]};
      or2_r  <= mag_c[0] | mag_c[1] | mag_c[2];

      ctl3_r <= ctl2_r;
      e3_r   <= e2_r;
      n3_r   <= n2_r;
      mag3_r <= mag2_r;
      sgn3_r <= sgn2_r;
      sh3_r  <= sh_c;

      ctl4_r <= ctl3_r;
      e4_r   <= e3_r;
      n4_r   <= n3_r;
      for (int i = 0; i < 3; i++) begin
        np4_r[i] <= sgn3_r[i] ? -$signed({1'b0, (RED_W-1)'(mag3_r[i] >> sh3_r)})
                              :  $signed({1'b0, (RED_W-1)'(mag3_r[i] >> sh3_r)});
      end

      ctl5_r  <= ctl4_r;
      e5_r    <= e4_r;
      n5_r    <= n4_r;
      y5_r[0] <= np4_r[1] * e4_r[2] - np4_r[2] * e4_r[1];
      y5_r[1] <= np4_r[2] * e4_r[0] - np4_r[0] * e4_r[2];
      y5_r[2] <= np4_r[0] * e4_r[1] - np4_r[1] * e4_r[0];

      ctl6_r.valid <= ctl5_r.valid;
      ctl6_r.bad   <= ctl5_r.bad || (y5_r[0] == '0 && y5_r[1] == '0 && y5_r[2] == '0);
      e6_r.x <= VEC_W'(e5_r[0]);
      e6_r.y <= VEC_W'(e5_r[1]);
      e6_r.z <= VEC_W'(e5_r[2]);
      n6_r.x <= VEC_W'(n5_r[0]);
      n6_r.y <= VEC_W'(n5_r[1]);
      n6_r.z <= VEC_W'(n5_r[2]);
      y6_r.x <= y5_r[0];
      y6_r.y <= y5_r[1];
      y6_r.z <= y5_r[2];
    end
  end

  assign out_ctl = ctl6_r;
  assign out_e   = e6_r;
  assign out_n   = n6_r;
  assign out_y   = y6_r;

endmodule

[design/efr_unit.sv]
// ---------------------------------------------------------------------------
// efr_unit
// Scales one vector to unit length: normalise, square sum, pipelined
// square root, then one restoring divide stage per quotient bit.
// ---------------------------------------------------------------------------
module efr_unit
  import efr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  efr_ctl_t ctl_i,
  input  efr_vec_t vec_i,
  output efr_ctl_t ctl_o,
  output efr_col_t col_o
);

  logic signed [VEC_W-1:0] vin [3];
  logic [VEC_W-1:0]        mag_c [3];

  efr_ctl_t         ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r, ctl_o_r;
  logic [VEC_W-1:0] mag_a_r [3];
  logic [VEC_W-1:0] mag_b_r [3];
  logic [2:0]       sgn_a_r, sgn_b_r, sgn_c_r, sgn_d_r;
  logic [VEC_W-1:0] or_a_r;
  logic [POS_W-1:0] pos_b_r;
  logic [UNIT_W-1:0] u_c_r [3];
  logic [UNIT_W-1:0] u_d_r [3];
  logic [2*UNIT_W-1:0] sq_d_r [3];

  efr_ctl_t          sr_ctl_r  [ROOT_W+1];
  logic [SUM_W-1:0]  sr_sum_r  [ROOT_W+1];
  logic [ROOT_W+1:0] sr_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] sr_root_r [ROOT_W+1];
  logic [UNIT_W-1:0] sr_u_r    [ROOT_W+1][3];
  logic [2:0]        sr_sgn_r  [ROOT_W+1];

  efr_ctl_t          dv_ctl_r  [QUO_W+1];
  logic [ROOT_W-1:0] dv_root_r [QUO_W+1];
  logic [ROOT_W-1:0] dv_rem_r  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_low_r  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_q_r    [QUO_W+1][3];
  logic [2:0]        dv_sgn_r  [QUO_W+1];

  logic signed [COMP_W-1:0] comp_r [3];
  logic [NUM_W-1:0]         num_c [3];

  assign vin[0] = vec_i.x;
  assign vin[1] = vec_i.y;
  assign vin[2] = vec_i.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vin[i][VEC_W-1] ? (~vin[i] + 1'b1) : vin[i];
      num_c[i] = NUM_W'({sr_u_r[ROOT_W][i], {FRAC_BITS{1'b0}}})
               + NUM_W'(sr_root_r[ROOT_W] >> 1);
    end
  end

  // normalise and square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r     <= '0;
      ctl_b_r     <= '0;
      ctl_c_r     <= '0;
      ctl_d_r     <= '0;
      sr_ctl_r[0] <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      mag_a_r <= mag_c;
      sgn_a_r <= {vin[2][VEC_W-1], vin[1][VEC_W-1], vin[0][VEC_W-1]};
      or_a_r  <= mag_c[0] | mag_c[1] | mag_c[2];

      ctl_b_r <= ctl_a_r;
      mag_b_r <= mag_a_r;
      sgn_b_r <= sgn_a_r;
      pos_b_r <= efr_msb(or_a_r);

      ctl_c_r <= ctl_b_r;
      sgn_c_r <= sgn_b_r;
      for (int i = 0; i < 3; i++) begin
        if (pos_b_r >= POS_W'(FRAC_BITS)) begin
          u_c_r[i] <= UNIT_W'(mag_b_r[i] >> (pos_b_r - POS_W'(FRAC_BITS)));
        end else begin
          u_c_r[i] <= UNIT_W'(mag_b_r[i] << (POS_W'(FRAC_BITS) - pos_b_r));
        end
      end

      ctl_d_r <= ctl_c_r;
      sgn_d_r <= sgn_c_r;
      u_d_r   <= u_c_r;
      for (int i = 0; i < 3; i++) begin
        sq_d_r[i] <= u_c_r[i] * u_c_r[i];
      end

      sr_ctl_r[0]  <= ctl_d_r;
      sr_sgn_r[0]  <= sgn_d_r;
      sr_u_r[0]    <= u_d_r;
      sr_sum_r[0]  <= SUM_W'(sq_d_r[0]) + SUM_W'(sq_d_r[1]) + SUM_W'(sq_d_r[2]);
      sr_rem_r[0]  <= '0;
      sr_root_r[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [ROOT_W+3:0] rem_t;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              take;

    always_comb begin
      rem_t = {sr_rem_r[k], sr_sum_r[k][SUM_W-1-2*k -: 2]};
      trial = {2'b00, sr_root_r[k], 2'b01};
      diff  = rem_t - trial;
      take  = (rem_t >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_ctl_r[k+1] <= '0;
      end else if (en) begin
        sr_ctl_r[k+1]  <= sr_ctl_r[k];
        sr_sgn_r[k+1]  <= sr_sgn_r[k];
        sr_u_r[k+1]    <= sr_u_r[k];
        sr_sum_r[k+1]  <= sr_sum_r[k];
        sr_rem_r[k+1]  <= take ? diff[ROOT_W+1:0] : rem_t[ROOT_W+1:0];
        sr_root_r[k+1] <= {sr_root_r[k][ROOT_W-2:0], take};
      end
    end
  end

  // dividend with half-divisor rounding term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl_r[0] <= '0;
    end else if (en) begin
      dv_ctl_r[0]  <= sr_ctl_r[ROOT_W];
      dv_sgn_r[0]  <= sr_sgn_r[ROOT_W];
      dv_root_r[0] <= sr_root_r[ROOT_W];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= ROOT_W'(num_c[i][NUM_W-1:QUO_W]);
        dv_low_r[0][i] <= num_c[i][QUO_W-1:0];
        dv_q_r[0][i]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [ROOT_W:0] t [3];
    logic [ROOT_W:0] d [3];
    logic [2:0]      take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {dv_rem_r[j][i], dv_low_r[j][i][QUO_W-1-j]};
        d[i]    = t[i] - {1'b0, dv_root_r[j]};
        take[i] = (t[i] >= {1'b0, dv_root_r[j]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl_r[j+1] <= '0;
      end else if (en) begin
        dv_ctl_r[j+1]  <= dv_ctl_r[j];
        dv_sgn_r[j+1]  <= dv_sgn_r[j];
        dv_root_r[j+1] <= dv_root_r[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j+1][i] <= take[i] ? d[i][ROOT_W-1:0] : t[i][ROOT_W-1:0];
          dv_low_r[j+1][i] <= dv_low_r[j][i];
          dv_q_r[j+1][i]   <= {dv_q_r[j][i][QUO_W-2:0], take[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o_r <= '0;
    end else if (en) begin
      ctl_o_r <= dv_ctl_r[QUO_W];
      for (int i = 0; i < 3; i++) begin
        comp_r[i] <= dv_sgn_r[QUO_W][i] ? (COMP_W'(0) - {1'b0, dv_q_r[QUO_W][i]})
                                        : {1'b0, dv_q_r[QUO_W][i]};
      end
    end
  end

  assign ctl_o   = ctl_o_r;
  assign col_o.x = comp_r[0];
  assign col_o.y = comp_r[1];
  assign col_o.z = comp_r[2];

endmodule

[design/element_frame_rotation_matrix_top.sv]
// ---------------------------------------------------------------------------
// element_frame_rotation_matrix_top
// Orthonormal local frame (tangent, in-plane, normal) of a mesh element.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data set the element kind (1 line, 2 planar, 3 volume);
//   write it only while no request is in flight. Reset selects volume.
//   in_valid/in_ready carry one request of three corner points; out_valid/
//   out_ready return one frame per request, in order, columns in Q1.30.
//   frame_status is 1 with all components zero for a degenerate element.
// Timing:
//   One request per cycle sustained while out_ready stays high. The front
//   register loads at the accepting edge; the request then passes 1 queue
//   slot, 6 cross-product stages, 70 unit stages (32 square-root and 31
//   divide stages dominate) and the output register to out_valid.
// Stalls:
//   While out_valid is high and out_ready low the back pipeline holds; the
//   front keeps taking requests until the four-entry queue fills, then
//   in_ready drops. Reset empties the pipeline and queue.
// ---------------------------------------------------------------------------
module element_frame_rotation_matrix_top
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  efr_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output efr_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  efr_kind_t kind_r;
  logic      push, q_full, q_empty, pop, en;
  efr_job_t  push_data, head;
  efr_ctl_t  x_ctl;
  efr_vec_t  x_e, x_n, x_y;
  efr_ctl_t  u_ctl [3];
  efr_col_t  u_col [3];
  logic      out_valid_r;
  efr_out_t  out_data_r;
  efr_out_t  out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_UNIT;
    end else if (cfg_wr_en) begin
      kind_r <= efr_kind_t'(cfg_wr_data);
    end
  end

  efr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .kind      (kind_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  efr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_empty;

  efr_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (!q_empty),
    .in_job   (head),
    .out_ctl  (x_ctl),
    .out_e    (x_e),
    .out_n    (x_n),
    .out_y    (x_y)
  );

  efr_unit u_tangent (
    .clk (clk), .rst_n (rst_n), .en (en),
    .ctl_i (x_ctl), .vec_i (x_e), .ctl_o (u_ctl[0]), .col_o (u_col[0])
  );

  efr_unit u_inplane (
    .clk (clk), .rst_n (rst_n), .en (en),
    .ctl_i (x_ctl), .vec_i (x_y), .ctl_o (u_ctl[1]), .col_o (u_col[1])
  );

  efr_unit u_normal (
    .clk (clk), .rst_n (rst_n), .en (en),
    .ctl_i (x_ctl), .vec_i (x_n), .ctl_o (u_ctl[2]), .col_o (u_col[2])
  );

  always_comb begin
    out_nxt = '0;
    out_nxt.frame_status = u_ctl[0].bad;
    if (!u_ctl[0].bad) begin
      out_nxt.tangent_x = u_col[0].x;
      out_nxt.tangent_y = u_col[0].y;
      out_nxt.tangent_z = u_col[0].z;
      out_nxt.inplane_x = u_col[1].x;
      out_nxt.inplane_y = u_col[1].y;
      out_nxt.inplane_z = u_col[1].z;
      out_nxt.normal_x  = u_col[2].x;
      out_nxt.normal_y  = u_col[2].y;
      out_nxt.normal_z  = u_col[2].z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= u_ctl[0].valid;
      out_data_r  <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the three unit pipelines run in lock step
  a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (u_ctl[0] == u_ctl[1]) && (u_ctl[1] == u_ctl[2]))
    else $error("unit pipelines out of step");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_status |->
      out_data.tangent_x == '0 && out_data.tangent_y == '0 &&
      out_data.tangent_z == '0 && out_data.inplane_x == '0 &&
      out_data.inplane_y == '0 && out_data.inplane_z == '0 &&
      out_data.normal_x == '0 && out_data.normal_y == '0 &&
      out_data.normal_z == '0)
    else $error("degenerate frame with nonzero components");

  a_tangent_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_status |->
      out_data.tangent_x != '0 || out_data.tangent_y != '0 ||
      out_data.tangent_z != '0)
    else $error("valid frame with zero tangent");

endmodule
